// ----- hw/rtl/sds_pkg.sv -----
// Shared constants, types and state encoding for the SCAN disk scheduler.
package sds_pkg;

   localparam int MAX_REQUESTS = 32;
   localparam int CYL_BITS     = 16;
   localparam int SEEK_W       = 22;
   localparam int CNT_W        = $clog2(MAX_REQUESTS + 1);
   localparam int IDX_W        = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;

   localparam int REQ_DATA_W   = ((CYL_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_W  = 2 * CYL_BITS + SEEK_W + 1;
   localparam int RSP_DATA_W   = ((RSP_FIELD_W + 7) / 8) * 8;

   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_START_HEAD   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_END_CYLINDER = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SWEEP_RIGHT  = 2'd2;

   localparam logic [CYL_BITS-1:0] RESET_START_HEAD   = '0;
   localparam logic [CYL_BITS-1:0] RESET_END_CYLINDER = '1;
   localparam logic [SEEK_W-1:0]   SEEK_MAX           = '1;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SPLIT,
      ST_FETCH,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic split;
      logic fetch;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic final_step;
   } status_type;

endpackage

// ----- hw/rtl/scan_disk_scheduler_unit.sv -----
// SCAN disk scheduler top level: request stream in, service-order stream out.
// Requests load one per cycle into a sorted register chain of 32 entries;
// requests beyond that are dropped and flagged in every result of the batch.
// The transfer marked tlast starts scheduling: the split state locates the
// split between the lower and upper requests, then each result passes the
// fetch state (select the next cylinder), then the emit state (compute
// distance and saturated seek sum, held while the result side stalls), so a
// batch of n stored requests yields n + 1 results. Requests are not taken
// while a batch is being emitted; the next batch may start as soon as the
// final result sits in the output register.
module scan_disk_scheduler_unit
   import sds_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_IDX_W-1:0]   csr_index,   // 0 start_head, 1 end_cylinder, 2 sweep_right
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,   // [15:0] cylinder
   input  logic                   req_tlast,   // last_request
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // [15:0] position, [31:16] step_distance,
                                               // [53:32] total_seek, [54] overflow
   output logic                   rsp_tlast    // last_step
);

   cmd_type    ctl_cmd;
   status_type dp_status;

   sds_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .status     (dp_status),
      .cmd        (ctl_cmd)
   );

   sds_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .cmd        (ctl_cmd),
      .status     (dp_status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   a_stop_after_last: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> !req_tready)
      else $error("request side still open after last transfer");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(ctl_cmd.emit))
      else $error("result valid without an emit");

   a_split_then_fetch: assert property (@(posedge clock) disable iff (reset)
      ctl_cmd.split |=> ctl_cmd.fetch)
      else $error("split not followed by fetch");

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctl_cmd.load, ctl_cmd.split, ctl_cmd.fetch, ctl_cmd.emit}))
      else $error("more than one datapath command");

endmodule

// ----- hw/rtl/sds_ctrl.sv -----
// Sequencer for loading requests, locating the sweep split and emitting the service order.
module sds_ctrl
   import sds_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tlast,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_tvalid && req_tlast) begin
               state_in = ST_SPLIT;
            end
         end
         ST_SPLIT: begin
            state_in = ST_FETCH;
         end
         ST_FETCH: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               state_in = status.final_step ? ST_LOAD : ST_FETCH;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_LOAD: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_SPLIT: begin
            cmd.split = 1'b1;
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
         end
         ST_EMIT: begin
            cmd.emit = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ----- hw/rtl/sds_datapath.sv -----
// Sorted request chain, split finder, sweep walker, seek arithmetic and result register.
module sds_datapath
   import sds_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   input  cmd_type                cmd,
   output status_type             status,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   output logic                   rsp_tlast
);

   logic [CYL_BITS-1:0] start_head_ff;
   logic [CYL_BITS-1:0] end_cyl_ff;
   logic                sweep_right_ff;

   logic [CYL_BITS-1:0] store_ff [MAX_REQUESTS];
   logic [CYL_BITS-1:0] store_in [MAX_REQUESTS];
   logic [CNT_W-1:0]    count_ff;
   logic                dropped_ff;

   logic [CNT_W-1:0]    hi_ff;
   logic [CNT_W-1:0]    lo_ff;
   logic                end_done_ff;
   logic [CYL_BITS-1:0] pos_ff;
   logic                last_ff;
   logic [CYL_BITS-1:0] cur_ff;
   logic [SEEK_W-1:0]   sum_ff;

   logic                rsp_valid_ff;
   logic [CYL_BITS-1:0] rsp_pos_ff;
   logic [CYL_BITS-1:0] rsp_dist_ff;
   logic [SEEK_W-1:0]   rsp_sum_ff;
   logic                rsp_ovf_ff;
   logic                rsp_last_ff;

   logic [CYL_BITS-1:0] cyl;
   logic                gt   [MAX_REQUESTS];
   logic                pgt  [MAX_REQUESTS];
   logic [CYL_BITS-1:0] pval [MAX_REQUESTS];
   logic                has_room;
   logic                below [MAX_REQUESTS];
   logic [CNT_W-1:0]    split_v;

   logic                up_rem;
   logic                down_rem;
   logic                first_rem;
   logic                second_rem;
   logic                take_end;
   logic                take_first;
   logic                take_up;
   logic [CNT_W-1:0]    hi_next;
   logic [CNT_W-1:0]    lo_next;
   logic [CNT_W-1:0]    lo_m1;
   logic [CYL_BITS-1:0] end_pos;
   logic [CYL_BITS-1:0] fetch_pos;
   logic                fetch_last;

   logic [CYL_BITS-1:0] step_dist;
   logic [SEEK_W:0]     sum_wide;
   logic [SEEK_W-1:0]   sum_sat;
   logic                out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_head_ff  <= RESET_START_HEAD;
         end_cyl_ff     <= RESET_END_CYLINDER;
         sweep_right_ff <= 1'b1;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_START_HEAD:   start_head_ff  <= csr_wdata[CYL_BITS-1:0];
            CSR_END_CYLINDER: end_cyl_ff     <= csr_wdata[CYL_BITS-1:0];
            CSR_SWEEP_RIGHT:  sweep_right_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   assign cyl      = req_tdata[CYL_BITS-1:0];
   assign has_room = (count_ff < CNT_W'(MAX_REQUESTS));

   always_comb begin
      for (int k = 0; k < MAX_REQUESTS; k++) begin
         gt[k] = (CNT_W'(k) >= count_ff) || (store_ff[k] > cyl);
      end
      pgt[0]  = 1'b0;
      pval[0] = cyl;
      for (int k = 1; k < MAX_REQUESTS; k++) begin
         pgt[k]  = gt[k-1];
         pval[k] = store_ff[k-1];
      end
      for (int k = 0; k < MAX_REQUESTS; k++) begin
         store_in[k] = store_ff[k];
         if (cmd.load && has_room && (CNT_W'(k) <= count_ff) && gt[k]) begin
            store_in[k] = pgt[k] ? pval[k] : cyl;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < MAX_REQUESTS; k++) begin
         store_ff[k] <= store_in[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         dropped_ff <= 1'b0;
      end else if (cmd.emit && last_ff) begin
         count_ff   <= '0;
         dropped_ff <= 1'b0;
      end else if (cmd.load) begin
         if (has_room) begin
            count_ff <= count_ff + CNT_W'(1);
         end else begin
            dropped_ff <= 1'b1;
         end
      end
   end

   always_comb begin
      split_v = '0;
      for (int k = 0; k < MAX_REQUESTS; k++) begin
         below[k] = (CNT_W'(k) < count_ff) &&
                    (sweep_right_ff ? (store_ff[k] < start_head_ff)
                                    : (store_ff[k] <= start_head_ff));
      end
      for (int k = 0; k < MAX_REQUESTS - 1; k++) begin
         if (below[k] && !below[k+1]) begin
            split_v = split_v | CNT_W'(k + 1);
         end
      end
      if (below[MAX_REQUESTS-1]) begin
         split_v = split_v | CNT_W'(MAX_REQUESTS);
      end
   end

   assign up_rem     = (hi_ff < count_ff);
   assign down_rem   = (lo_ff != '0);
   assign first_rem  = sweep_right_ff ? up_rem : down_rem;
   assign second_rem = sweep_right_ff ? down_rem : up_rem;
   assign take_first = !end_done_ff && first_rem;
   assign take_end   = !end_done_ff && !first_rem;
   assign take_up    = take_first ? sweep_right_ff : !sweep_right_ff;
   assign hi_next    = hi_ff + CNT_W'(1);
   assign lo_m1      = lo_ff - CNT_W'(1);
   assign lo_next    = lo_m1;
   assign end_pos    = sweep_right_ff ? end_cyl_ff : '0;

   always_comb begin
      if (take_end) begin
         fetch_pos  = end_pos;
         fetch_last = !second_rem;
      end else if (take_up) begin
         fetch_pos  = store_ff[hi_ff[IDX_W-1:0]];
         fetch_last = !take_first && (hi_next == count_ff);
      end else begin
         fetch_pos  = store_ff[lo_m1[IDX_W-1:0]];
         fetch_last = !take_first && (lo_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         end_done_ff <= 1'b0;
         last_ff     <= 1'b0;
      end else if (cmd.split) begin
         end_done_ff <= 1'b0;
         last_ff     <= 1'b0;
      end else if (cmd.fetch) begin
         last_ff <= fetch_last;
         if (take_end) begin
            end_done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.split) begin
         hi_ff  <= split_v;
         lo_ff  <= split_v;
         cur_ff <= start_head_ff;
         sum_ff <= '0;
      end else if (cmd.fetch) begin
         pos_ff <= fetch_pos;
         if (!take_end) begin
            if (take_up) begin
               hi_ff <= hi_next;
            end else begin
               lo_ff <= lo_next;
            end
         end
      end else if (cmd.emit) begin
         cur_ff <= pos_ff;
         sum_ff <= sum_sat;
      end
   end

   assign step_dist = (pos_ff >= cur_ff) ? (pos_ff - cur_ff) : (cur_ff - pos_ff);
   assign sum_wide  = {1'b0, sum_ff} + (SEEK_W + 1)'(step_dist);
   assign sum_sat   = sum_wide[SEEK_W] ? SEEK_MAX : sum_wide[SEEK_W-1:0];
   assign out_free  = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_pos_ff  <= pos_ff;
         rsp_dist_ff <= step_dist;
         rsp_sum_ff  <= sum_sat;
         rsp_ovf_ff  <= dropped_ff;
         rsp_last_ff <= last_ff;
      end
   end

   assign status.out_free   = out_free;
   assign status.final_step = last_ff;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_ovf_ff, rsp_sum_ff, rsp_dist_ff, rsp_pos_ff});
   assign rsp_tlast  = rsp_last_ff;

endmodule
